// ----- src/msufp_pkg.sv -----
package msufp_pkg;

	localparam int unsigned MASK_W    = 8;
	localparam int unsigned CUR_W     = 16;
	localparam int unsigned WIDE_W    = 32;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned GROUP_W   = 7;
	localparam int unsigned NUM_FIELDS = 6;

	localparam logic [GROUP_W-1:0] GROUP_MASK = 7'h7f;
	localparam logic [BYTE_W-1:0]  MORE_FLAG  = 8'h80;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

endpackage

// ----- src/msufp_item_if.sv -----
interface msufp_item_if;
	logic                                 valid;
	logic                                 ready;
	logic [msufp_pkg::MASK_W-1:0]         present_mask;
	logic [msufp_pkg::CUR_W-1:0]          current_phase1;
	logic [msufp_pkg::CUR_W-1:0]          current_phase2;
	logic [msufp_pkg::CUR_W-1:0]          current_phase3;
	logic [msufp_pkg::WIDE_W-1:0]         active_power;
	logic [msufp_pkg::WIDE_W-1:0]         energy_tariff_one;
	logic [msufp_pkg::WIDE_W-1:0]         energy_tariff_two;

	modport source (
		output valid, present_mask, current_phase1, current_phase2, current_phase3,
		output active_power, energy_tariff_one, energy_tariff_two,
		input  ready
	);
	modport sink (
		input  valid, present_mask, current_phase1, current_phase2, current_phase3,
		input  active_power, energy_tariff_one, energy_tariff_two,
		output ready
	);
endinterface

// ----- src/msufp_byte_if.sv -----
interface msufp_byte_if;
	logic                         valid;
	logic                         ready;
	logic [msufp_pkg::BYTE_W-1:0] out_byte;
	logic                         last_byte;

	modport source (output valid, out_byte, last_byte, input ready);
	modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

// ----- src/mask_selected_uleb128_field_packer.sv -----
// Mask-selected unsigned LEB128 field packer.
//
// item (sink): one transfer carries present_mask and six meter readings.
// stream (source): one transfer per encoded byte, out_byte plus last_byte,
// last_byte high on the final byte of the message.
// The message is the mask as unsigned LEB128, then every reading whose mask
// bit 0 to 5 is set, in field order, each as unsigned LEB128.
//
// The item transfer moves the sequencer to ST_EMIT; from there the first
// byte is loaded into the byte register. One shared 7-bit shift-and-test
// step produces one byte per cycle while the receiver takes them, so a
// message is N bytes (1 to 26); item.ready is high only between messages,
// so a new item waits until the final byte is in the byte register.
//
// The byte register parts the two sides: when the receiver stalls, the
// byte waits in it and the encoder holds until it is taken.
// Reset clears the sequencer and the byte valid; no message is pending.
module mask_selected_uleb128_field_packer (
	input  logic           clk,
	input  logic           arst_n,
	msufp_item_if.sink     item,
	msufp_byte_if.source   stream
);

	msufp_pkg::state_t                   state_q, state_d;
	logic [msufp_pkg::NUM_FIELDS-1:0]    rem_q, rem_d;
	logic [msufp_pkg::WIDE_W-1:0]        value_q, value_d;
	logic [msufp_pkg::CUR_W-1:0]         cur1_q, cur2_q, cur3_q;
	logic [msufp_pkg::WIDE_W-1:0]        pwr_q, en1_q, en2_q;
	logic                                out_valid_q, out_valid_d;
	logic [msufp_pkg::BYTE_W-1:0]        out_byte_q;
	logic                                out_last_q;

	logic                                accept;
	logic                                load_out;
	logic [msufp_pkg::WIDE_W-1:0]        rest;
	logic                                more;
	logic [msufp_pkg::BYTE_W-1:0]        byte_d;
	logic                                last_d;
	logic [msufp_pkg::WIDE_W-1:0]        next_val;

	assign item.ready       = (state_q == msufp_pkg::ST_IDLE);
	assign accept           = item.valid && item.ready;
	assign stream.valid     = out_valid_q;
	assign stream.out_byte  = out_byte_q;
	assign stream.last_byte = out_last_q;

	// shared step: one 7-bit group off the current value
	assign load_out = (state_q == msufp_pkg::ST_EMIT) && (!out_valid_q || stream.ready);
	assign rest     = value_q >> msufp_pkg::GROUP_W;
	assign more     = |rest;
	assign byte_d   = (more ? msufp_pkg::MORE_FLAG : '0)
			| {1'b0, value_q[msufp_pkg::GROUP_W-1:0] & msufp_pkg::GROUP_MASK};
	assign last_d   = !more && (rem_q == '0);

	// lowest selected field still to send
	always_comb begin
		priority if (rem_q[0]) begin
			next_val = {{(msufp_pkg::WIDE_W-msufp_pkg::CUR_W){1'b0}}, cur1_q};
		end else if (rem_q[1]) begin
			next_val = {{(msufp_pkg::WIDE_W-msufp_pkg::CUR_W){1'b0}}, cur2_q};
		end else if (rem_q[2]) begin
			next_val = {{(msufp_pkg::WIDE_W-msufp_pkg::CUR_W){1'b0}}, cur3_q};
		end else if (rem_q[3]) begin
			next_val = pwr_q;
		end else if (rem_q[4]) begin
			next_val = en1_q;
		end else begin
			next_val = en2_q;
		end
	end

	always_comb begin
		state_d     = state_q;
		rem_d       = rem_q;
		value_d     = value_q;
		out_valid_d = out_valid_q;
		if (stream.ready) begin
			out_valid_d = 1'b0;
		end
		unique case (state_q)
			msufp_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = msufp_pkg::ST_EMIT;
					rem_d   = item.present_mask[msufp_pkg::NUM_FIELDS-1:0];
					value_d = {{(msufp_pkg::WIDE_W-msufp_pkg::MASK_W){1'b0}},
						item.present_mask};
				end
			end
			msufp_pkg::ST_EMIT: begin
				if (load_out) begin
					out_valid_d = 1'b1;
					if (more) begin
						value_d = rest;
					end else if (rem_q != '0) begin
						value_d = next_val;
						rem_d   = rem_q & (rem_q - 1'b1);
					end else begin
						state_d = msufp_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = msufp_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= msufp_pkg::ST_IDLE;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rem_q       <= rem_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
		if (accept) begin
			cur1_q <= item.current_phase1;
			cur2_q <= item.current_phase2;
			cur3_q <= item.current_phase3;
			pwr_q  <= item.active_power;
			en1_q  <= item.energy_tariff_one;
			en2_q  <= item.energy_tariff_two;
		end
		if (load_out) begin
			out_byte_q <= byte_d;
			out_last_q <= last_d;
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == msufp_pkg::ST_EMIT))
		else $error("item transfer did not start a message");

	a_last_no_more: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_last_q) |-> !out_byte_q[msufp_pkg::BYTE_W-1])
		else $error("final byte carries the continuation bit");

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == msufp_pkg::ST_IDLE) |-> (rem_q == '0))
		else $error("fields left unsent at end of message");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && last_d) |=> (state_q == msufp_pkg::ST_IDLE))
		else $error("sequencer kept running after the final byte");

endmodule
